>>> sv/cvp_pkg.sv
// Shared types and constants for the code/value command parser.
// No dependencies; every other file depends on this package.
`default_nettype none

package cvp_pkg;

  // Character codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharComma = 8'h2C;

  // Length limits
  localparam logic [3:0] LenMin     = 4'd3;
  localparam logic [3:0] LenMax     = 4'd9;
  localparam logic [1:0] CodeLenMax = 2'd2;

  // Saturation points
  localparam logic [3:0]  CountSat = 4'd15;
  localparam logic [1:0]  CommaSat = 2'd3;
  localparam logic [1:0]  DigitSat = 2'd3;
  localparam logic [6:0]  CodeSat  = 7'd127;
  localparam logic [23:0] ValueSat = 24'hFF_FFFF;

  // Status codes
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusBadLength = 3'd1;
  localparam logic [2:0] StatusBadChar   = 3'd2;
  localparam logic [2:0] StatusCommas    = 3'd3;
  localparam logic [2:0] StatusCodeLen   = 3'd4;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } cvp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  code;
    logic [23:0] value;
    logic        code_is_zero;
  } cvp_out_t;

  // Result handed from the parse core to the output stage
  typedef struct packed {
    logic     valid;
    cvp_out_t data;
  } cvp_res_t;

endpackage

`default_nettype wire

>>> sv/cvp_if.sv
// Valid/ready channel interfaces for the command parser.
// Depends on cvp_pkg for the payload types.
`default_nettype none

interface cvp_in_if;
  logic             valid;
  logic             ready;
  cvp_pkg::cvp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cvp_out_if;
  logic              valid;
  logic              ready;
  cvp_pkg::cvp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/code_value_command_parser.sv
// Top level of the code/value command parser: parse core plus output register
// with skid stage. Depends on cvp_pkg, cvp_if and cvp_core.
//
//   Port    Dir  Payload                              Transaction
//   in_i    in   character[7:0], is_last              one character
//   out_o   out  status, code, value, code_is_zero    one result per string
//
// One character per cycle while the skid slot is empty; a string's result is
// registered (skid slot if the output stalls) once its last character is taken.
// Reset clears all counters, accumulators and both output slot valid flags.
// A stalled output fills the skid slot; input ready drops only while it is full.
`default_nettype none

module code_value_command_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cvp_in_if.sink    in_i,
  cvp_out_if.source out_o
);
  import cvp_pkg::*;

  logic     accept;
  logic     pop;
  cvp_res_t res;

  logic     out_valid_q;
  cvp_out_t out_data_q;
  logic     skid_valid_q;
  cvp_out_t skid_data_q;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && !skid_valid_q;
  assign pop        = out_valid_q && out_o.ready;

  cvp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.data),
    .res_o    (res)
  );

  // Output slot control: drain skid first, else take the new result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res.valid) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output slot payloads
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_data_q <= skid_data_q;
    end else if (res.valid) begin
      if (!out_valid_q || pop) begin
        out_data_q <= res.data;
      end else begin
        skid_data_q <= res.data;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

>>> sv/cvp_core.sv
// Parse core: per-string counters and decimal accumulators, status decode.
// Depends on cvp_pkg.
`default_nettype none

module cvp_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire cvp_pkg::cvp_in_t item_i,
  output cvp_pkg::cvp_res_t     res_o
);
  import cvp_pkg::*;

  logic [3:0]  char_count_q, char_count_d;
  logic [1:0]  comma_count_q, comma_count_d;
  logic        bad_char_q, bad_char_d;
  logic [1:0]  digit_count_q, digit_count_d;
  logic [6:0]  code_acc_q, code_acc_d;
  logic [23:0] value_acc_q, value_acc_d;

  logic        is_comma;
  logic        is_digit;
  logic [3:0]  digit;
  logic [10:0] code_mul;
  logic [27:0] value_mul;
  logic [2:0]  status;

  // Classify the character and form the times-ten sums
  always_comb begin
    is_comma  = (item_i.character == CharComma);
    is_digit  = (item_i.character >= CharZero) && (item_i.character <= CharNine);
    digit     = 4'(item_i.character - CharZero);
    code_mul  = {code_acc_q, 3'b000} + {2'b00, code_acc_q, 1'b0} + {7'd0, digit};
    value_mul = {1'b0, value_acc_q, 3'b000} + {3'b000, value_acc_q, 1'b0}
              + {24'd0, digit};
  end

  // Advance the counters and accumulators for this character
  always_comb begin
    char_count_d  = (char_count_q < CountSat) ? char_count_q + 4'd1 : char_count_q;
    comma_count_d = comma_count_q;
    bad_char_d    = bad_char_q;
    digit_count_d = digit_count_q;
    code_acc_d    = code_acc_q;
    value_acc_d   = value_acc_q;
    if (is_comma) begin
      if (comma_count_q < CommaSat) comma_count_d = comma_count_q + 2'd1;
    end else if (is_digit) begin
      if (comma_count_q == 2'd0) begin
        if (digit_count_q < DigitSat) digit_count_d = digit_count_q + 2'd1;
        code_acc_d = (code_mul > 11'(CodeSat)) ? CodeSat : code_mul[6:0];
      end else if (comma_count_q == 2'd1) begin
        value_acc_d = (value_mul > 28'(ValueSat)) ? ValueSat : value_mul[23:0];
      end
    end else begin
      bad_char_d = 1'b1;
    end
  end

  // Decode status from the updated state, first failing check wins
  always_comb begin
    if (char_count_d < LenMin || char_count_d > LenMax) begin
      status = StatusBadLength;
    end else if (bad_char_d) begin
      status = StatusBadChar;
    end else if (comma_count_d > 2'd1) begin
      status = StatusCommas;
    end else if (comma_count_d == 2'd0 || digit_count_d < 2'd1
                 || digit_count_d > CodeLenMax) begin
      status = StatusCodeLen;
    end else begin
      status = StatusOk;
    end
  end

  assign res_o.valid             = accept_i && item_i.is_last;
  assign res_o.data.status       = status;
  assign res_o.data.code         = code_acc_d;
  assign res_o.data.value        = value_acc_d;
  assign res_o.data.code_is_zero = (code_acc_d == 7'd0);

  // Hold state between characters, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q  <= '0;
      comma_count_q <= '0;
      bad_char_q    <= 1'b0;
      digit_count_q <= '0;
      code_acc_q    <= '0;
      value_acc_q   <= '0;
    end else if (accept_i) begin
      if (item_i.is_last) begin
        char_count_q  <= '0;
        comma_count_q <= '0;
        bad_char_q    <= 1'b0;
        digit_count_q <= '0;
        code_acc_q    <= '0;
        value_acc_q   <= '0;
      end else begin
        char_count_q  <= char_count_d;
        comma_count_q <= comma_count_d;
        bad_char_q    <= bad_char_d;
        digit_count_q <= digit_count_d;
        code_acc_q    <= code_acc_d;
        value_acc_q   <= value_acc_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for code_value_command_parser: directed table with
// hand-written results plus random command strings, checked against a cycle-free parser model.
// Depends on cvp_pkg, cvp_if and the code_value_command_parser RTL.

module testbench;
  import cvp_pkg::*;

  localparam int RandomChars = 2000;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int IdlePct     = 26;
  localparam int ResetCycles = 11;
  localparam int SteadyStart = 1500;
  localparam int SteadyEnd   = 2300;
  localparam int DirRows     = 26;

  // One character with an optional hand-written expected result
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    cvp_out_t   res;
  } dir_row_t;

  typedef struct packed {
    cvp_in_t  item;
    logic     typed;
    cvp_out_t res;
  } char_entry_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_cnt  = 0;
  int   mismatches = 0;
  logic steady;

  char_entry_t char_q[$];
  cvp_out_t    pending_results[$];

  cvp_in_if  in_ch ();
  cvp_out_if out_ch ();

  code_value_command_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  assign steady = (cycle_cnt >= SteadyStart) && (cycle_cnt < SteadyEnd);

  // Directed strings: minimal ok with zero code, longest ok, single bad byte,
  // bad character, comma first and doubled, no comma, empty value
  dir_row_t dir_tbl [DirRows] = '{
    '{"0", 1'b0, 1'b0, '0},
    '{",", 1'b0, 1'b0, '0},
    '{"0", 1'b1, 1'b1, '{StatusOk, 7'd0, 24'd0, 1'b1}},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{",", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b1, 1'b1, '{StatusOk, 7'd99, 24'd999999, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{StatusBadLength, 7'd0, 24'd0, 1'b1}},
    '{"1", 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{",", 1'b0, 1'b0, '0},
    '{"2", 1'b1, 1'b1, '{StatusBadChar, 7'd1, 24'd2, 1'b0}},
    '{",", 1'b0, 1'b0, '0},
    '{",", 1'b0, 1'b0, '0},
    '{"1", 1'b1, 1'b1, '{StatusCommas, 7'd0, 24'd0, 1'b1}},
    '{"1", 1'b0, 1'b0, '0},
    '{"2", 1'b0, 1'b0, '0},
    '{"3", 1'b1, 1'b1, '{StatusCodeLen, 7'd123, 24'd0, 1'b0}},
    '{"1", 1'b0, 1'b0, '0},
    '{"2", 1'b0, 1'b0, '0},
    '{",", 1'b1, 1'b1, '{StatusOk, 7'd12, 24'd0, 1'b0}}
  };

  // Parser state as seen by the predictor
  logic [3:0]  len_cnt   = '0;
  logic [1:0]  comma_cnt = '0;
  logic        bad_seen  = 1'b0;
  logic [1:0]  code_len  = '0;
  logic [6:0]  code_acc  = '0;
  logic [23:0] value_acc = '0;

  function automatic logic [31:0] shift_in_digit(logic [31:0] acc, logic [7:0] ch,
                                                 logic [31:0] sat);
    logic [31:0] nxt;
    nxt = acc * 32'd10 + 32'(ch - CharZero);
    return (nxt > sat) ? sat : nxt;
  endfunction

  // Advance the parser by one character; return 1 with the result on the last one
  function automatic logic parse_char(input cvp_in_t c, output cvp_out_t res);
    logic [2:0] st;
    res = '0;
    if (len_cnt != CountSat) len_cnt = len_cnt + 4'd1;
    if (c.character == CharComma) begin
      if (comma_cnt != CommaSat) comma_cnt = comma_cnt + 2'd1;
    end else if (c.character >= CharZero && c.character <= CharNine) begin
      if (comma_cnt == 2'd0) begin
        if (code_len != DigitSat) code_len = code_len + 2'd1;
        code_acc = 7'(shift_in_digit(32'(code_acc), c.character, 32'(CodeSat)));
      end else if (comma_cnt == 2'd1) begin
        value_acc = 24'(shift_in_digit(32'(value_acc), c.character, 32'(ValueSat)));
      end
    end else begin
      bad_seen = 1'b1;
    end
    if (!c.is_last) return 1'b0;

    // First failing check wins
    if (len_cnt < LenMin || len_cnt > LenMax) st = StatusBadLength;
    else if (bad_seen) st = StatusBadChar;
    else if (comma_cnt > 2'd1) st = StatusCommas;
    else if (comma_cnt == 2'd0 || code_len < 2'd1 || code_len > CodeLenMax) st = StatusCodeLen;
    else st = StatusOk;
    res.status       = st;
    res.code         = code_acc;
    res.value        = value_acc;
    res.code_is_zero = (code_acc == 7'd0);

    // Return to the idle state for the next string
    len_cnt   = '0;
    comma_cnt = '0;
    bad_seen  = 1'b0;
    code_len  = '0;
    code_acc  = '0;
    value_acc = '0;
    return 1'b1;
  endfunction

  // Drive characters; predict each transaction as it is accepted
  always @(posedge clk_i) begin : drive_chars
    logic     offer;
    cvp_out_t res;
    if (rst_ni) begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        if (parse_char(char_q[0].item, res))
          pending_results.push_back(char_q[0].typed ? char_q[0].res : res);
        void'(char_q.pop_front());
        offer = 1'b0;
      end
      if (!offer && char_q.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        in_ch.data <= char_q[0].item;
        offer = 1'b1;
      end
      in_ch.valid <= offer;
    end
  end

  // Compare each accepted result with the oldest expectation; stall at random
  always @(posedge clk_i) begin : check_results
    cvp_out_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d code %0d value %0d code_is_zero %0d",
                 out_ch.data.status, out_ch.data.code, out_ch.data.value,
                 out_ch.data.code_is_zero);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.data.status);
            mismatches++;
          end
          if (out_ch.data.code !== want.code) begin
            $error("code: expected %0d, got %0d", want.code, out_ch.data.code);
            mismatches++;
          end
          if (out_ch.data.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.data.value);
            mismatches++;
          end
          if (out_ch.data.code_is_zero !== want.code_is_zero) begin
            $error("code_is_zero: expected %0d, got %0d", want.code_is_zero,
                   out_ch.data.code_is_zero);
            mismatches++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : run
    logic [7:0] text [$];
    int         n_random;
    int         kind;
    int         code_digits;
    int         value_digits;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;

    // Walk the directed table
    for (int i = 0; i < DirRows; i++)
      char_q.push_back(char_entry_t'{cvp_in_t'{dir_tbl[i].ch, dir_tbl[i].last},
                                     dir_tbl[i].typed, dir_tbl[i].res});

    // Random strings: mostly well formed, the rest broken or pure noise
    n_random = 0;
    while (n_random < RandomChars) begin
      text.delete();
      kind = $urandom_range(99);
      if (kind >= 96) begin
        repeat ($urandom_range(12, 1)) text.push_back(8'($urandom_range(255)));
      end else begin
        if (kind >= 84 && kind < 90) code_digits = $urandom_range(5);
        else code_digits = $urandom_range(2, 1);
        if (kind >= 90) value_digits = $urandom_range(14, 8);
        else if (kind >= 84) value_digits = $urandom_range(4);
        else value_digits = $urandom_range(8 - code_digits);
        repeat (code_digits) text.push_back(CharZero + 8'($urandom_range(9)));
        if (kind < 88 || kind >= 90) text.push_back(CharComma);
        repeat (value_digits) text.push_back(CharZero + 8'($urandom_range(9)));
        if (text.size() == 0) text.push_back(CharZero + 8'($urandom_range(9)));
        // Corrupt one character, or add stray commas
        if (kind >= 70 && kind < 78)
          text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        if (kind >= 78 && kind < 84)
          repeat ($urandom_range(3, 1)) text.insert($urandom_range(text.size()), CharComma);
      end
      foreach (text[i])
        char_q.push_back(char_entry_t'{cvp_in_t'{text[i], 1'(i == text.size() - 1)},
                                       1'b0, '0});
      n_random += text.size();
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every character to go in and every result to come out
    while (char_q.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cvp_pkg.sv
sv/cvp_if.sv
sv/cvp_core.sv
sv/code_value_command_parser.sv
tb/testbench.sv
